/* sv/smdp_pkg.sv */
// smdp_pkg: widths, register and mode codes, DTMF tone tables and the
// half-bin tone test shared by the spectral mask and DTMF picker.
// No dependencies.
package smdp_pkg;

  localparam int FREQ_W    = 40;
  localparam int AMP_W     = 16;
  localparam int SPACING_W = 24;
  localparam int MODE_W    = 3;
  localparam int HIGH_HZ_W = 11;
  localparam int LOW_HZ_W  = 10;
  localparam int N_HIGH    = 3;
  localparam int N_LOW     = 4;
  localparam int HCODE_W   = 2;
  localparam int LCODE_W   = 3;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [MODE_W-1:0] MODE_LOWPASS  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HIGHPASS = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BANDPASS = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BANDSTOP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DTMF     = 3'd4;

  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_SPACING  = 2'd1;
  localparam logic [1:0] REG_CUT_LOW  = 2'd2;
  localparam logic [1:0] REG_CUT_HIGH = 2'd3;

  localparam logic [SPACING_W-1:0] SPACING_RST = 24'd2560;
  localparam logic [FREQ_W-1:0]    CUT_OFFSET  = 40'd256;

  localparam logic [HIGH_HZ_W-1:0] HIGH_TONES [N_HIGH] = '{11'd1209, 11'd1336, 11'd1477};
  localparam logic [LOW_HZ_W-1:0]  LOW_TONES  [N_LOW]  =
    '{10'd697, 10'd770, 10'd852, 10'd941};

  typedef logic [FREQ_W-1:0]    freq_t;
  typedef logic [SPACING_W-1:0] spacing_t;
  typedef logic signed [AMP_W-1:0] amp_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    spacing_t          spacing;
    spacing_t          cut_low;
    spacing_t          cut_high;
  } cfg_t;

  // |2*F - 512*T| <= spacing
  function automatic logic tone_near(freq_t freq, logic [HIGH_HZ_W-1:0] tone,
                                     spacing_t spacing);
    logic [FREQ_W:0] twice;
    logic [FREQ_W:0] t;
    logic [FREQ_W:0] d;
    twice = {freq, 1'b0};
    t     = {21'd0, tone, 9'd0};
    d     = (twice >= t) ? (twice - t) : (t - twice);
    return d <= {17'd0, spacing};
  endfunction

endpackage

/* sv/smdp_cfg.sv */
// smdp_cfg: APB-style register file for mode, bin spacing and cutoffs.
// Depends on smdp_pkg.
module smdp_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [smdp_pkg::ADDR_W-1:0] paddr,
  input  logic [smdp_pkg::DATA_W-1:0] pwdata,
  output logic [smdp_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output smdp_pkg::cfg_t              cfg
);
  import smdp_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_MODE:     cfg_nxt.mode     = pwdata[MODE_W-1:0];
        REG_SPACING:  cfg_nxt.spacing  = pwdata[SPACING_W-1:0];
        REG_CUT_LOW:  cfg_nxt.cut_low  = pwdata[SPACING_W-1:0];
        REG_CUT_HIGH: cfg_nxt.cut_high = pwdata[SPACING_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MODE:     prdata = {29'd0, cfg_r.mode};
      REG_SPACING:  prdata = {8'd0, cfg_r.spacing};
      REG_CUT_LOW:  prdata = {8'd0, cfg_r.cut_low};
      REG_CUT_HIGH: prdata = {8'd0, cfg_r.cut_high};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode     <= MODE_LOWPASS;
      cfg_r.spacing  <= SPACING_RST;
      cfg_r.cut_low  <= '0;
      cfg_r.cut_high <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* sv/smdp_tone.sv */
// smdp_tone: matches a bin frequency against the column and row tone
// tables; first tone in list order wins. Depends on smdp_pkg.
module smdp_tone (
  input  smdp_pkg::freq_t              freq,
  input  smdp_pkg::spacing_t           spacing,
  output logic [smdp_pkg::HCODE_W-1:0] hcode,
  output logic [smdp_pkg::LCODE_W-1:0] lcode
);
  import smdp_pkg::*;

  always_comb begin
    hcode = '0;
    for (int k = N_HIGH - 1; k >= 0; k--) begin
      if (tone_near(freq, HIGH_TONES[k], spacing)) begin
        hcode = HCODE_W'(k + 1);
      end
    end
  end

  always_comb begin
    lcode = '0;
    for (int k = N_LOW - 1; k >= 0; k--) begin
      if (tone_near(freq, {1'b0, LOW_TONES[k]}, spacing)) begin
        lcode = LCODE_W'(k + 1);
      end
    end
  end

endmodule

/* sv/spectral_mask_and_dtmf_picker.sv */
// spectral_mask_and_dtmf_picker: top level with bin frequency accumulator,
// input stage, mask and DTMF pick logic and result register.
// Depends on smdp_pkg, smdp_cfg, smdp_tone.
//
// Usage: spectrum bins enter one word per cycle on the in_ channel
// (in_valid/in_stall), with in_last_bin on the final bin of a spectrum.
// Bin i is taken to lie at i * bin_spacing. In mask modes every bin gives
// one out_ word; in DTMF mode only the final bin gives a word, carrying the
// strongest column and row tones found in that spectrum.
// Flow: an accepted word waits in the input stage and is loaded into the
// result register when that stage advances, raising out_valid if it emits.
// Throughput: one bin per cycle while in_stall is low; the input stage
// and result register form a two-entry pipeline, and the input stage
// advances whenever the result register is empty or being taken.
// Stall: with out_stall high and a result held, the input stage fills and
// in_stall is high while it holds a word.
// Reset (rst_n low, synchronous): stages empty, bin frequency and tone
// picks cleared, registers reset. The user must write configuration via
// the APB-style port only while no word is in flight; it is not enforced.
module spectral_mask_and_dtmf_picker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [smdp_pkg::ADDR_W-1:0]   paddr,
  input  logic [smdp_pkg::DATA_W-1:0]   pwdata,
  output logic [smdp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [smdp_pkg::AMP_W-1:0] in_bin_amplitude,
  input  logic                          in_last_bin,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [smdp_pkg::AMP_W-1:0] out_amplitude_out,
  output logic [smdp_pkg::HIGH_HZ_W-1:0] out_high_tone_hz,
  output logic [smdp_pkg::LOW_HZ_W-1:0] out_low_tone_hz,
  output logic                          out_last_out
);
  import smdp_pkg::*;

  cfg_t cfg;

  freq_t freq_r, freq_nxt;
  logic [FREQ_W:0] freq_sum;

  logic  s1_valid_r, s1_valid_nxt;
  amp_t  s1_amp_r;
  logic  s1_last_r;
  freq_t s1_freq_r;

  amp_t               hbest_r, hbest_nxt, hbest_upd;
  logic [HCODE_W-1:0] hcode_r, hcode_nxt, hcode_upd;
  logic               hfound_r, hfound_nxt, hfound_upd;
  amp_t               lbest_r, lbest_nxt, lbest_upd;
  logic [LCODE_W-1:0] lcode_r, lcode_nxt, lcode_upd;
  logic               lfound_r, lfound_nxt, lfound_upd;

  logic               out_valid_r, out_valid_nxt;
  amp_t               out_amp_r, out_amp_nxt;
  logic [HIGH_HZ_W-1:0] out_high_r, out_high_nxt;
  logic [LOW_HZ_W-1:0]  out_low_r, out_low_nxt;
  logic               out_last_r;

  logic in_accept, s1_adv, s1_done, dtmf, emit, keep, h_take, l_take;
  logic [HCODE_W-1:0] hcode_bin;
  logic [LCODE_W-1:0] lcode_bin;
  logic [1:0]         hidx, lidx;
  freq_t              lim1, lim2;

  smdp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  smdp_tone u_tone (
    .freq    (s1_freq_r),
    .spacing (cfg.spacing),
    .hcode   (hcode_bin),
    .lcode   (lcode_bin)
  );

  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign s1_done   = s1_valid_r && s1_adv;

  assign freq_sum = {1'b0, freq_r} + {17'd0, cfg.spacing};
  always_comb begin
    freq_nxt = freq_r;
    if (in_accept) begin
      if (in_last_bin) begin
        freq_nxt = '0;
      end else if (freq_sum[FREQ_W]) begin
        freq_nxt = '1;
      end else begin
        freq_nxt = freq_sum[FREQ_W-1:0];
      end
    end
  end

  assign s1_valid_nxt = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

  assign dtmf = (cfg.mode == MODE_DTMF);
  assign emit = !dtmf || s1_last_r;
  assign lim1 = {15'd0, cfg.cut_low, 1'b0} + CUT_OFFSET;
  assign lim2 = {15'd0, cfg.cut_high, 1'b0} + CUT_OFFSET;

  always_comb begin
    unique case (cfg.mode)
      MODE_LOWPASS:  keep = s1_freq_r < lim1;
      MODE_HIGHPASS: keep = s1_freq_r > lim1;
      MODE_BANDPASS: keep = (s1_freq_r > lim1) && (s1_freq_r < lim2);
      MODE_BANDSTOP: keep = (s1_freq_r < lim1) || (s1_freq_r > lim2);
      default:       keep = 1'b1;
    endcase
  end

  assign h_take = dtmf && (hcode_bin != '0) && (!hfound_r || (s1_amp_r > hbest_r));
  assign l_take = dtmf && (lcode_bin != '0) && (!lfound_r || (s1_amp_r > lbest_r));

  assign hbest_upd  = h_take ? s1_amp_r : hbest_r;
  assign hcode_upd  = h_take ? hcode_bin : hcode_r;
  assign hfound_upd = hfound_r || h_take;
  assign lbest_upd  = l_take ? s1_amp_r : lbest_r;
  assign lcode_upd  = l_take ? lcode_bin : lcode_r;
  assign lfound_upd = lfound_r || l_take;

  assign hidx = hcode_upd - 2'd1;
  assign lidx = 2'(lcode_upd - 3'd1);

  always_comb begin
    hbest_nxt  = hbest_r;
    hcode_nxt  = hcode_r;
    hfound_nxt = hfound_r;
    lbest_nxt  = lbest_r;
    lcode_nxt  = lcode_r;
    lfound_nxt = lfound_r;
    if (s1_done) begin
      if (s1_last_r) begin
        hbest_nxt  = '0;
        hcode_nxt  = '0;
        hfound_nxt = 1'b0;
        lbest_nxt  = '0;
        lcode_nxt  = '0;
        lfound_nxt = 1'b0;
      end else begin
        hbest_nxt  = hbest_upd;
        hcode_nxt  = hcode_upd;
        hfound_nxt = hfound_upd;
        lbest_nxt  = lbest_upd;
        lcode_nxt  = lcode_upd;
        lfound_nxt = lfound_upd;
      end
    end
  end

  assign out_amp_nxt   = (!dtmf && keep) ? s1_amp_r : '0;
  assign out_high_nxt  = (dtmf && hfound_upd) ? HIGH_TONES[hidx] : '0;
  assign out_low_nxt   = (dtmf && lfound_upd) ? LOW_TONES[lidx] : '0;
  assign out_valid_nxt = s1_adv ? (s1_valid_r && emit) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hbest_r     <= '0;
      hcode_r     <= '0;
      hfound_r    <= 1'b0;
      lbest_r     <= '0;
      lcode_r     <= '0;
      lfound_r    <= 1'b0;
    end else begin
      freq_r      <= freq_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      hbest_r     <= hbest_nxt;
      hcode_r     <= hcode_nxt;
      hfound_r    <= hfound_nxt;
      lbest_r     <= lbest_nxt;
      lcode_r     <= lcode_nxt;
      lfound_r    <= lfound_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_amp_r  <= in_bin_amplitude;
      s1_last_r <= in_last_bin;
      s1_freq_r <= freq_r;
    end
    if (s1_done && emit) begin
      out_amp_r  <= out_amp_nxt;
      out_high_r <= out_high_nxt;
      out_low_r  <= out_low_nxt;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_amplitude_out = out_amp_r;
  assign out_high_tone_hz  = out_high_r;
  assign out_low_tone_hz   = out_low_r;
  assign out_last_out      = out_last_r;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled while pipeline has room");

  a_freq_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_last_bin |=> freq_r == '0)
    else $error("bin frequency not restarted after final bin");

  a_freq_grow: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !in_last_bin |=> freq_r >= $past(freq_r))
    else $error("bin frequency decreased within a spectrum");

  a_tone_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_high_r != '0 || out_low_r != '0) |-> out_last_r && out_amp_r == '0)
    else $error("tone reported on a non-final or masked word");

endmodule
